// ===== src/bppr_pkg.sv =====
// Package for the buffer pool page replacer.
// Holds sizes, operation, status and config index codes. No dependencies.
package bppr_pkg;
  localparam int SLOTS = 64;
  localparam int SW = $clog2(SLOTS);
  localparam int KW = 32;
  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_PIN    = 2'd1;
  localparam logic [1:0] OP_UNPIN  = 2'd2;
  localparam logic [1:0] OP_DIRTY  = 2'd3;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOVIC  = 2'd1;
  localparam logic [1:0] ST_NORES  = 2'd2;
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_SLOTS = 1'b1;
endpackage

// ===== src/buffer_pool_page_replacer.sv =====
// Top level of the buffer pool page replacer.
// Depends on bppr_pkg.
//
// Use: pulse start with operation and page_key while busy is low. The block
// scans the slot table one slot per cycle under a small sequencer with one
// shared key compare and one shared time compare. The lookup walks all SLOTS
// key entries, then the read state S_FIN and the result state S_RES follow.
// A hit, a pin, unpin or dirty, or a miss into the empty hand slot goes
// straight on to them. A miss that must evict first runs a victim scan of
// the slots in use (SLOTS at most). busy drops in the done cycle.
// The result is on the output ports for one cycle marked by done;
// the receiver cannot stall. Config writes (cfg_valid/cfg_ready, cfg_index,
// cfg_data) are taken at any time and must only be issued while idle.
// Synchronous reset clears slot valid, dirty, pinned, history counts, hand
// and time; key and history memories need no clearing.
module buffer_pool_page_replacer
  import bppr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    operation,
  input  logic [31:0]   page_key,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  output logic          done,
  output logic          hit,
  output logic [5:0]    slot_index,
  output logic          evicted_valid,
  output logic [31:0]   evicted_page,
  output logic          write_back,
  output logic [1:0]    status
);
  localparam logic [2:0] S_IDLE = 3'd0, S_LOOK = 3'd1, S_VIC = 3'd2,
                         S_FIN = 3'd3, S_RES = 3'd4;
  logic [2:0] state;
  logic lru_k_mode;
  logic [6:0] slots_in_use;
  logic [SLOTS-1:0] vld, drt, pin;
  logic [1:0] hcnt [SLOTS];
  logic [KW-1:0] pmem [SLOTS];
  logic [KW-1:0] h0 [SLOTS];
  logic [KW-1:0] h1 [SLOTS];
  logic [SW-1:0] hand, rd_a, idx, best_s;
  logic [6:0] cnt, n;
  logic [KW-1:0] time_now, pd, h0d, h1d, best_t, key;
  logic [1:0] op;
  logic found, have, rd_v;
  logic [SW-1:0] rd_s;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);
  assign n = (slots_in_use == 7'd0) ? 7'd1 :
             (slots_in_use > 7'(SLOTS)) ? 7'(SLOTS) : slots_in_use;

  always_ff @(posedge clk) begin
    pd  <= pmem[rd_a];
    h0d <= h0[rd_a];
    h1d <= h1[rd_a];
  end

  // oldest-of-history for the slot read last cycle
  logic [KW-1:0] t_old;
  logic cand;
  assign t_old = (!vld[rd_s] || hcnt[rd_s] == 2'd0) ? '0 : h0d;
  assign cand = !(vld[rd_s] && pin[rd_s]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; lru_k_mode <= 1'b0; slots_in_use <= 7'd64;
      vld <= '0; drt <= '0; pin <= '0; hand <= '0; time_now <= '0;
      done <= 1'b0; rd_v <= 1'b0;
      for (int i = 0; i < SLOTS; i++) hcnt[i] <= 2'd0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MODE) lru_k_mode <= cfg_data[0];
        else slots_in_use <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= operation; key <= page_key; found <= 1'b0; have <= 1'b0;
            rd_a <= '0; cnt <= '0; rd_v <= 1'b0;
            if ({1'b0, hand} >= n) hand <= '0;
            if (operation == OP_ACCESS && lru_k_mode && time_now != '1)
              time_now <= time_now + 1'b1;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          rd_s <= rd_a; rd_v <= (cnt < 7'(SLOTS));
          rd_a <= rd_a + 1'b1; cnt <= cnt + 1'b1;
          if (rd_v && !found && vld[rd_s] && pd == key) begin
            found <= 1'b1; idx <= rd_s;
          end
          if (!rd_v && cnt != 0) begin
            cnt <= '0;
            if (found || op != OP_ACCESS) begin
              rd_a <= idx; state <= S_FIN;
            end else if (!vld[hand]) begin
              idx <= hand; have <= 1'b1; state <= S_FIN;
              hand <= ({1'b0, hand} + 7'd1 >= n) ? '0 : hand + 1'b1;
            end else begin
              rd_a <= lru_k_mode ? '0 : hand; state <= S_VIC;
            end
          end
        end
        S_VIC: begin
          rd_s <= rd_a; rd_v <= (cnt < n);
          cnt <= cnt + 1'b1;
          rd_a <= ({1'b0, rd_a} + 7'd1 >= n) ? '0 : rd_a + 1'b1;
          if (rd_v && cand) begin
            if (!lru_k_mode) begin
              if (!have) begin
                have <= 1'b1; idx <= rd_s;
                hand <= ({1'b0, rd_s} + 7'd1 >= n) ? '0 : rd_s + 1'b1;
              end
            end else if (!have || t_old < best_t) begin
              have <= 1'b1; idx <= rd_s; best_t <= t_old;
            end
          end
          if (!rd_v && cnt != 0) begin
            rd_a <= idx; state <= S_FIN;
          end
        end
        S_FIN: begin
          rd_a <= idx; state <= S_RES;
        end
        default: begin
          hit <= 1'b0; slot_index <= '0; evicted_valid <= 1'b0;
          evicted_page <= '0; write_back <= 1'b0; status <= ST_OK;
          done <= 1'b1; state <= S_IDLE;
          if (found) begin
            hit <= 1'b1; slot_index <= 6'(idx);
            if (op == OP_PIN) pin[idx] <= 1'b1;
            else if (op == OP_UNPIN) pin[idx] <= 1'b0;
            else if (op == OP_DIRTY) drt[idx] <= 1'b1;
            else if (lru_k_mode) begin
              if (hcnt[idx] == 2'd2) begin
                h0[idx] <= h1d; h1[idx] <= time_now;
              end else if (hcnt[idx] == 2'd1) begin
                h1[idx] <= time_now; hcnt[idx] <= 2'd2;
              end else begin
                h0[idx] <= time_now; hcnt[idx] <= 2'd1;
              end
            end
          end else if (op != OP_ACCESS) status <= ST_NORES;
          else if (!have) status <= ST_NOVIC;
          else begin
            slot_index <= 6'(idx);
            if (vld[idx]) begin
              evicted_valid <= 1'b1; evicted_page <= pd; write_back <= drt[idx];
            end
            vld[idx] <= 1'b1; pmem[idx] <= key; drt[idx] <= 1'b0; pin[idx] <= 1'b0;
            if (lru_k_mode) begin
              h0[idx] <= time_now; hcnt[idx] <= 2'd1;
            end else hcnt[idx] <= 2'd0;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_ev_ok: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> (status == ST_OK && !hit)) else $error("bad evict");
`endif
endmodule
